// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int OPC_W = 2;
  localparam int STAT_W = 2;
  localparam int SHOWN_W = 8;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPC_W-1:0] OP_PEEK = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Broadcast to every cell in the chain for one transaction
  typedef struct packed {
    logic insert;
    logic remove;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell
  import spq_pkg::*;
(
  input  logic clk,
  input  cell_ctl_t ctl,
  input  logic occupied,
  input  logic signed [VALUE_W-1:0] prev_entry,
  input  logic prev_ge,
  input  logic signed [VALUE_W-1:0] next_entry,
  output logic signed [VALUE_W-1:0] entry,
  output logic ge
);

  logic signed [VALUE_W-1:0] entry_next;

  // Entry stays ahead of the new value when it is greater or equal
  assign ge = occupied && !(entry < ctl.value);

  always_comb begin
    entry_next = entry;
    if (ctl.insert) begin
      if (ge) begin
        entry_next = entry;
      end else if (prev_ge) begin
        entry_next = ctl.value;
      end else begin
        entry_next = prev_entry;
      end
    end else if (ctl.remove) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Max-priority queue of up to DEPTH signed 32-bit values, kept sorted in a
// chain of cells with the largest value at the head; equal values leave in
// arrival order. Every cell compares and shifts at one edge, so insert
// (tuser 0), remove (1) and peek (2) are accepted every cycle while the
// output is not stalled, each result being captured in the output
// register on acceptance. Insert on a full queue returns status full,
// remove or peek on an empty queue returns status empty with value zero.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [1:0] s_tuser,    // opcode[1:0]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [47:0] m_tdata,   // top_value[31:0], entry_count[39:32], is_empty[40], zero
  output logic [1:0] m_tuser     // status[1:0]
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CNTX_W = (CNT_W > SHOWN_W) ? CNT_W : SHOWN_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNTX_W-1:0] count_x;
  logic [SHOWN_W-1:0] shown;
  logic accept;
  logic full;
  logic empty;
  logic [STAT_W-1:0] status;
  logic signed [VALUE_W-1:0] top;
  cell_ctl_t ctl;

  logic signed [VALUE_W-1:0] entries [DEPTH];
  logic ge [DEPTH];

  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;
  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctl.insert = 1'b0;
    ctl.remove = 1'b0;
    ctl.value = s_tdata;
    status = ST_DONE;
    top = '0;
    count_next = count;
    case (s_tuser)
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.insert = accept;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.remove = accept;
          top = entries[0];
          count_next = count - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          top = entries[0];
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  assign count_x = CNTX_W'(count_next);
  assign shown = (count_x > CNTX_W'(255)) ? 8'hFF : count_x[SHOWN_W-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_entry;
    logic prev_ge;
    logic signed [VALUE_W-1:0] next_entry;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_ge = 1'b1;
    end else begin : g_body
      assign prev_entry = entries[i-1];
      assign prev_ge = ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk(clk),
      .ctl(ctl),
      .occupied(count > CNT_W'(i)),
      .prev_entry(prev_entry),
      .prev_ge(prev_ge),
      .next_entry(next_entry),
      .entry(entries[i]),
      .ge(ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0, (count_next == '0), shown, top};
      m_tuser <= status;
    end
  end

endmodule

// ===== hdl/spq_checker.sv =====
module spq_checker
  import spq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0] m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result blocks the input and holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(s_tvalid && s_tready) ##1
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |->
      m_tdata[40] && m_tdata[39:32] == 8'd0 && m_tdata[31:0] == 32'd0)
    else $error("empty refusal carries data or count");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> !m_tdata[40] && m_tdata[31:0] == 32'd0)
    else $error("full refusal reports empty queue or a value");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[40] == (m_tdata[39:32] == 8'd0))
    else $error("empty flag disagrees with count");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser)
);
